// ----- src/btbp_pkg.sv -----
// Package for the branch target buffer predictor: default sizes, counter
// constants and the command codes. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package btbp_pkg;

  // Port width of every address field
  localparam int unsigned ADDR_W = 64;

  // Default sizes
  localparam int unsigned ENTRIES_DEF = 512;
  localparam int unsigned PC_BITS_DEF = 64;

  // Two-bit saturating counter
  localparam logic [1:0] CTR_MIN             = 2'd0;
  localparam logic [1:0] CTR_MAX             = 2'd3;
  localparam logic [1:0] CTR_PREDICT_TAKEN   = 2'd2;
  localparam logic [1:0] CTR_ALLOC_TAKEN     = 2'd2;
  localparam logic [1:0] CTR_ALLOC_NOT_TAKEN = 2'd1;

  // Item command
  typedef enum logic {
    CMD_PREDICT = 1'b0,
    CMD_UPDATE  = 1'b1
  } cmd_e;

endpackage

`default_nettype wire

// ----- src/branch_target_buffer_predictor_unit.sv -----
// Top level of the branch target buffer predictor: direct-mapped buffer with
// a 2-bit counter per entry. Uses btbp_pkg and btbp_ram.
//
//  channel | direction | signals
//  --------+-----------+-------------------------------------------------------
//  in      | input     | in_valid_i/in_ready_o: command, pc, seq_pc,
//          |           | resolved_pc, taken
//  out     | output    | out_valid_o/out_ready_i: next_pc (predict items only)
//
// Sequence: with ENTRIES a power of two the entry is read at acceptance, then
// resolved: a predict loads the output register, an update writes back;
// otherwise the index pc mod ENTRIES is first reduced 4 bits a cycle.
// Reset: a clearing pass writes every entry invalid, with in_ready_o low.
// Stalls: a predict item waits in resolve while the output register is full and
// not taken; an item is accepted while a finished result waits to be taken.
`timescale 1ns / 1ps
`default_nettype none

module branch_target_buffer_predictor_unit import btbp_pkg::*; #(
  parameter int unsigned ENTRIES = ENTRIES_DEF,
  parameter int unsigned PC_BITS = PC_BITS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic              in_command_i,
  input  wire logic [ADDR_W-1:0] in_pc_i,
  input  wire logic [ADDR_W-1:0] in_seq_pc_i,
  input  wire logic [ADDR_W-1:0] in_resolved_pc_i,
  input  wire logic              in_taken_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic      [ADDR_W-1:0] out_next_pc_o
);

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam bit          POW2  = (ENTRIES & (ENTRIES - 1)) == 0;

  // Entry layout: the whole address is kept as tag, so the tag compare is a
  // full address compare.
  typedef struct packed {
    logic               valid;
    logic [1:0]         ctr;
    logic [PC_BITS-1:0] target;
    logic [PC_BITS-1:0] tag;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef enum logic [3:0] {
    ST_CLEAR   = 4'b0001,
    ST_IDLE    = 4'b0010,
    ST_REDUCE  = 4'b0100,
    ST_RESOLVE = 4'b1000
  } state_e;

  state_e             state_q, state_d;
  logic [IDX_W-1:0]   clr_q, clr_d;
  logic [IDX_W-1:0]   idx_q;
  cmd_e               cmd_q;
  logic [PC_BITS-1:0] pc_q, fall_q, tgt_q;
  logic               taken_q;
  logic               out_valid_q, out_valid_d;
  logic [PC_BITS-1:0] out_pc_q, out_pc_d;

  logic               in_acc;
  logic               out_load;
  logic [IDX_W-1:0]   look_idx;
  logic               red_done;

  logic               ram_we, ram_re;
  logic [IDX_W-1:0]   ram_waddr;
  entry_t             ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t             rd_entry, upd_entry;
  logic               hit;

  assign in_acc     = in_valid_i & in_ready_o;
  assign in_ready_o = (state_q == ST_IDLE);

  // Index generation
  if (POW2) begin : g_idx_low
    // Low address bits, read issued at acceptance
    assign look_idx = in_pc_i[IDX_W-1:0];
    assign red_done = 1'b0;
  end else begin : g_idx_mod
    localparam int unsigned DIG   = (PC_BITS + 3) / 4;
    localparam int unsigned PAD_W = DIG * 4;
    localparam int unsigned CNT_W = $clog2(DIG);
    localparam int unsigned SUM_W = IDX_W + 4;
    localparam logic [SUM_W-1:0] MODV = SUM_W'(ENTRIES);

    logic [IDX_W-1:0] rem_q;
    logic [CNT_W-1:0] cnt_q;
    logic [PAD_W-1:0] pc_pad;
    logic [3:0]       digit;
    logic [SUM_W-1:0] part;

    assign pc_pad = PAD_W'(pc_q);
    assign digit  = pc_pad[cnt_q*4 +: 4];

    // Fold one hex digit into the remainder, four compare-subtract steps
    always_comb begin
      part = {rem_q, digit};
      for (int i = 3; i >= 0; i--) begin
        if (part >= (MODV << i)) begin
          part = part - (MODV << i);
        end
      end
    end

    // Walk the digits from the top
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        rem_q <= '0;
        cnt_q <= '0;
      end else if (in_acc) begin
        rem_q <= '0;
        cnt_q <= CNT_W'(DIG - 1);
      end else if (state_q == ST_REDUCE) begin
        rem_q <= part[IDX_W-1:0];
        cnt_q <= cnt_q - 1'b1;
      end
    end

    assign look_idx = part[IDX_W-1:0];
    assign red_done = (cnt_q == '0);
  end

  // Hit check and counter training
  assign rd_entry = entry_t'(ram_rdata);
  assign hit      = rd_entry.valid && (rd_entry.tag == pc_q);

  always_comb begin
    upd_entry       = rd_entry;
    upd_entry.valid = 1'b1;
    upd_entry.tag   = pc_q;
    if (!hit) begin
      upd_entry.target = tgt_q;
      upd_entry.ctr    = taken_q ? CTR_ALLOC_TAKEN : CTR_ALLOC_NOT_TAKEN;
    end else if (taken_q) begin
      upd_entry.target = tgt_q;
      if (rd_entry.ctr != CTR_MAX) begin
        upd_entry.ctr = rd_entry.ctr + 2'd1;
      end
    end else if (rd_entry.ctr != CTR_MIN) begin
      upd_entry.ctr = rd_entry.ctr - 2'd1;
    end
  end

  // Sequencer
  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = idx_q;
    ram_wdata = upd_entry;
    out_load  = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == IDX_W'(ENTRIES - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          if (POW2) begin
            ram_re  = 1'b1;
            state_d = ST_RESOLVE;
          end else begin
            state_d = ST_REDUCE;
          end
        end
      end
      ST_REDUCE: begin
        if (red_done) begin
          ram_re  = 1'b1;
          state_d = ST_RESOLVE;
        end
      end
      ST_RESOLVE: begin
        if (cmd_q == CMD_PREDICT) begin
          if (!out_valid_q || out_ready_i) begin
            out_load = 1'b1;
            state_d  = ST_IDLE;
          end
        end else begin
          ram_we  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  // Output register
  assign out_pc_d = (hit && (rd_entry.ctr >= CTR_PREDICT_TAKEN)) ? rd_entry.target : fall_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q   <= cmd_e'(in_command_i);
      pc_q    <= in_pc_i[PC_BITS-1:0];
      fall_q  <= in_seq_pc_i[PC_BITS-1:0];
      tgt_q   <= in_resolved_pc_i[PC_BITS-1:0];
      taken_q <= in_taken_i;
    end
    if (ram_re) begin
      idx_q <= look_idx;
    end
    if (out_load) begin
      out_pc_q <= out_pc_d;
    end
  end

  btbp_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(ENTRIES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(look_idx),
    .rdata_o(ram_rdata)
  );

  assign out_valid_o   = out_valid_q;
  assign out_next_pc_o = ADDR_W'(out_pc_q);

endmodule

`default_nettype wire

// ----- src/btbp_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module btbp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- src/btbp_checker.sv -----
// Port-level checks for the branch target buffer predictor, bound to the
// top level. Uses btbp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module btbp_checker import btbp_pkg::*; (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_ready_o,
  input wire logic              in_command_i,
  input wire logic              out_valid_o,
  input wire logic              out_ready_i,
  input wire logic [ADDR_W-1:0] out_next_pc_o
);

  // Hold a result until it is taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_next_pc_o))
    else $error("result dropped or changed while stalled");

  // Drop ready after an item is accepted: one item in flight
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second item accepted while one is in flight");

  // An update item never raises a result
  a_update_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_command_i == CMD_UPDATE) && !out_valid_o
    |=> !out_valid_o ##1 !out_valid_o)
    else $error("update item produced a result");

  // A predict item's result shows only after its entry has been read
  a_predict_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_command_i == CMD_PREDICT) && !out_valid_o
    |=> !out_valid_o)
    else $error("result appeared before the entry was read");

endmodule

bind branch_target_buffer_predictor_unit btbp_checker u_btbp_checker (.*);

`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking testbench for the branch target buffer predictor: directed
// and random predict/update items against a predictor of the buffer state.
// Depends on btbp_pkg and branch_target_buffer_predictor_unit.
`timescale 1ns / 1ps

module testbench;
  import btbp_pkg::*;

  localparam int unsigned IDX_W = $clog2(ENTRIES_DEF);
  localparam logic [ADDR_W-1:0] PC_MASK = {ADDR_W{1'b1}} >> (ADDR_W - PC_BITS_DEF);
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned RANDOM_ITEMS = 1425;

  // Tracks the buffer contents and the next_pc values still owed by the block
  class next_pc_tracker;
    bit                slot_valid[ENTRIES_DEF];
    logic [ADDR_W-1:0] slot_tag[ENTRIES_DEF];
    logic [ADDR_W-1:0] slot_target[ENTRIES_DEF];
    logic [1:0]        slot_ctr[ENTRIES_DEF];
    logic [ADDR_W-1:0] next_pc_due[$];
    int mismatches;
    int predicts;
    int updates;
    int target_hits;
    int allocs;

    function new();
      foreach (slot_valid[k]) slot_valid[k] = 1'b0;
      mismatches  = 0;
      predicts    = 0;
      updates     = 0;
      target_hits = 0;
      allocs      = 0;
    endfunction

    function int pending();
      return next_pc_due.size();
    endfunction

    // Apply one accepted item to the buffer copy; queue the next_pc of a predict
    function void record_item(cmd_e cmd, logic [ADDR_W-1:0] pc, logic [ADDR_W-1:0] ft,
                              logic [ADDR_W-1:0] tgt, logic tk);
      logic [ADDR_W-1:0] addr;
      logic [ADDR_W-1:0] tag_v;
      int unsigned       slot;
      bit                hit;
      addr  = pc & PC_MASK;
      slot  = int'(addr % ENTRIES_DEF);
      tag_v = addr / ENTRIES_DEF;
      hit   = slot_valid[slot] && (slot_tag[slot] == tag_v);
      if (cmd == CMD_PREDICT) begin
        predicts++;
        if (hit && slot_ctr[slot] >= CTR_PREDICT_TAKEN) begin
          target_hits++;
          next_pc_due.insert(next_pc_due.size(), slot_target[slot]);
        end else begin
          next_pc_due.insert(next_pc_due.size(), ft & PC_MASK);
        end
      end else begin
        updates++;
        if (!hit) begin
          // Allocate over whatever held the slot
          allocs++;
          slot_valid[slot]  = 1'b1;
          slot_tag[slot]    = tag_v;
          slot_target[slot] = tgt & PC_MASK;
          slot_ctr[slot]    = tk ? CTR_ALLOC_TAKEN : CTR_ALLOC_NOT_TAKEN;
        end else if (tk) begin
          if (slot_ctr[slot] != CTR_MAX) slot_ctr[slot] = slot_ctr[slot] + 2'd1;
          slot_target[slot] = tgt & PC_MASK;
        end else begin
          if (slot_ctr[slot] != CTR_MIN) slot_ctr[slot] = slot_ctr[slot] - 2'd1;
        end
      end
    endfunction

    function void report(string what, logic [ADDR_W-1:0] exp, logic [ADDR_W-1:0] act);
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s: next_pc expected %h, got %h", $realtime, what, exp, act);
    endfunction

    // Compare one taken result with the oldest expectation
    function void check_next_pc(logic [ADDR_W-1:0] act);
      logic [ADDR_W-1:0] exp;
      if (next_pc_due.size() == 0) begin
        report("result with none expected", 'x, act);
      end else begin
        exp = next_pc_due[0];
        next_pc_due.delete(0);
        if (act !== exp) report("mismatch", exp, act);
      end
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic              in_command_i = 1'b0;
  logic [ADDR_W-1:0] in_pc_i = '0;
  logic [ADDR_W-1:0] in_seq_pc_i = '0;
  logic [ADDR_W-1:0] in_resolved_pc_i = '0;
  logic              in_taken_i = 1'b0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [ADDR_W-1:0] out_next_pc_o;

  next_pc_tracker tracker;
  bit             sender_calm = 1'b0;
  bit             receiver_calm = 1'b0;
  bit             hold_off_go = 1'b0;
  logic [ADDR_W-1:0] pc_pool[32];

  branch_target_buffer_predictor_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .in_command_i    (in_command_i),
    .in_pc_i         (in_pc_i),
    .in_seq_pc_i     (in_seq_pc_i),
    .in_resolved_pc_i(in_resolved_pc_i),
    .in_taken_i      (in_taken_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_next_pc_o   (out_next_pc_o)
  );

  always #10 clk_i = ~clk_i;

  // Give up after a generous fixed time
  initial begin
    #3_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Check every next_pc taken at a rising edge
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) tracker.check_next_pc(out_next_pc_o);
  end

  // Drive out_ready_i: random stalls, one long hold-off, calm stretches
  initial begin : receiver
    int  stall_left;
    bit  hold_done;
    stall_left = 0;
    hold_done  = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_go && !hold_done) begin
        hold_done  = 1'b1;
        stall_left = HOLD_OFF_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (receiver_calm) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= ($urandom_range(99) >= 33);
      end
    end
  end

  // Offer one item from a falling edge; return at the falling edge after acceptance
  task automatic send_item(input cmd_e cmd, input logic [ADDR_W-1:0] pc,
                           input logic [ADDR_W-1:0] ft, input logic [ADDR_W-1:0] tgt,
                           input logic tk);
    while (!sender_calm && $urandom_range(99) < 33) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i       <= 1'b1;
    in_command_i     <= cmd;
    in_pc_i          <= pc;
    in_seq_pc_i      <= ft;
    in_resolved_pc_i <= tgt;
    in_taken_i       <= tk;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    tracker.record_item(cmd, pc, ft, tgt, tk);
    @(negedge clk_i);
  endtask

  // Hold the input idle until every owed next_pc has come back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (tracker.pending() != 0) @(negedge clk_i);
  endtask

  initial begin : stimulus
    logic [ADDR_W-1:0] a_pc;
    logic [ADDR_W-1:0] b_pc;
    logic [ADDR_W-1:0] ones;
    logic [ADDR_W-1:0] r_pc;
    cmd_e              r_cmd;
    tracker = new();
    ones = {ADDR_W{1'b1}};
    a_pc = 64'h0000_0000_0000_1040;
    b_pc = a_pc ^ 64'h8000_0000_0000_0000;

    // Half the pool shares an index with the other half under a different tag
    for (int k = 0; k < 32; k++) begin
      pc_pool[k] = {$urandom, $urandom};
      if (k >= 16) pc_pool[k][IDX_W-1:0] = pc_pool[k-16][IDX_W-1:0];
    end

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: empty buffer, counter walk up and down, saturation, tag conflict
    send_item(CMD_PREDICT, a_pc, 64'h1111, 64'h0, 1'b1);
    send_item(CMD_UPDATE,  a_pc, 64'h0, 64'hAAAA_0001, 1'b1);
    send_item(CMD_PREDICT, a_pc, 64'h2222, 64'h0, 1'b0);
    send_item(CMD_UPDATE,  a_pc, 64'h0, 64'hDEAD, 1'b0);
    send_item(CMD_PREDICT, a_pc, 64'h3333, 64'h0, 1'b0);
    send_item(CMD_UPDATE,  a_pc, 64'h0, 64'hAAAA_0002, 1'b1);
    send_item(CMD_UPDATE,  a_pc, 64'h0, 64'hAAAA_0003, 1'b1);
    send_item(CMD_UPDATE,  a_pc, 64'h0, 64'hAAAA_0004, 1'b1);
    send_item(CMD_PREDICT, a_pc, 64'h4444, 64'h0, 1'b0);
    send_item(CMD_UPDATE,  a_pc, 64'h0, 64'hBEEF, 1'b0);
    send_item(CMD_UPDATE,  a_pc, 64'h0, 64'hBEEF, 1'b0);
    send_item(CMD_PREDICT, a_pc, 64'h5555, 64'h0, 1'b0);
    send_item(CMD_UPDATE,  a_pc, 64'h0, 64'hBEEF, 1'b0);
    send_item(CMD_UPDATE,  a_pc, 64'h0, 64'hBEEF, 1'b0);
    send_item(CMD_PREDICT, a_pc, 64'h6666, 64'h0, 1'b0);
    send_item(CMD_UPDATE,  b_pc, 64'h0, 64'hBBBB, 1'b1);
    send_item(CMD_PREDICT, a_pc, 64'h7777, 64'h0, 1'b0);
    send_item(CMD_PREDICT, b_pc, 64'h8888, 64'h0, 1'b0);
    send_item(CMD_UPDATE,  64'h0, 64'h0, ones, 1'b1);
    send_item(CMD_PREDICT, 64'h0, 64'h0, ones, 1'b1);
    send_item(CMD_UPDATE,  ones, ones, 64'h0, 1'b1);
    send_item(CMD_PREDICT, ones, ones, ones, 1'b1);
    send_item(CMD_UPDATE,  64'h0000_0000_0000_0123, ones, 64'h1234, 1'b0);
    send_item(CMD_PREDICT, 64'h0000_0000_0000_0123, ones, ones, 1'b1);
    drain_results();

    // Random: mostly a small pool of branches so entries train and conflict
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      sender_calm   = (i >= 400 && i < 600) || (i >= 700 && i < 900);
      receiver_calm = (i >= 700 && i < 900);
      if (i == 400) hold_off_go = 1'b1;
      if (i == 1000) drain_results();
      r_pc  = ($urandom_range(99) < 85) ? pc_pool[$urandom_range(31)] : {$urandom, $urandom};
      r_cmd = ($urandom_range(99) < 50) ? CMD_UPDATE : CMD_PREDICT;
      send_item(r_cmd, r_pc, {$urandom, $urandom}, {$urandom, $urandom},
                $urandom_range(99) < 60);
    end
    drain_results();
    repeat (10) @(posedge clk_i);

    $display("Ran %0d predict and %0d update items: %0d predictions from stored targets,",
             tracker.predicts, tracker.updates, tracker.target_hits);
    $display("%0d entries allocated, %0d mismatches, %0d results still owed.",
             tracker.allocs, tracker.mismatches, tracker.pending());
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
